// ----- rtl/rbd_pkg.sv -----
// Shared types and constants of the ring buffer deque.
`default_nettype none

package rbd_pkg;

   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 32;
   localparam int TOTAL_W  = 9;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_PEEK_FRONT = 3'd4,
      ACT_PEEK_BACK  = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_IN,
      CELL_SHIFT_OUT,
      CELL_APPEND,
      CELL_TRIM
   } cell_op_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic                      read_valid;
      logic [TOTAL_W-1:0]        entry_total;
      logic                      is_empty;
      logic                      push_dropped;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/rbd_req_if.sv -----
// Request channel interface of the ring buffer deque.
`default_nettype none

interface rbd_req_if
   import rbd_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [ACTION_W-1:0]       action;
   logic signed [VALUE_W-1:0] push_value;

   modport source (output valid, action, push_value, input ready);
   modport sink   (input valid, action, push_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/rbd_rsp_if.sv -----
// Response channel interface of the ring buffer deque.
`default_nettype none

interface rbd_rsp_if
   import rbd_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] read_value;
   logic                      read_valid;
   logic [TOTAL_W-1:0]        entry_total;
   logic                      is_empty;
   logic                      push_dropped;

   modport source (output valid, read_value, read_valid, entry_total, is_empty,
                   push_dropped, input ready);
   modport sink   (input valid, read_value, read_valid, entry_total, is_empty,
                   push_dropped, output ready);
endinterface

`default_nettype wire

// ----- rtl/rbd_cell.sv -----
// One storage cell of the deque chain: a word and an occupied flag.
`default_nettype none

module rbd_cell
   import rbd_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cell_op_type           op,
   input  wire logic [DATA_WIDTH-1:0] push_data,
   input  wire logic [DATA_WIDTH-1:0] left_data,
   input  wire logic                  left_valid,
   input  wire logic [DATA_WIDTH-1:0] right_data,
   input  wire logic                  right_valid,
   output logic [DATA_WIDTH-1:0]      data,
   output logic                       valid
);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic                  valid_ff, valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (op)
         CELL_SHIFT_IN: begin
            data_in  = left_data;
            valid_in = left_valid;
         end
         CELL_SHIFT_OUT: begin
            data_in  = right_data;
            valid_in = right_valid;
         end
         CELL_APPEND: begin
            // first free cell takes the word
            if (left_valid && !valid_ff) begin
               data_in  = push_data;
               valid_in = 1'b1;
            end
         end
         CELL_TRIM: begin
            // last occupied cell lets go
            if (valid_ff && !right_valid) begin
               valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

// ----- rtl/rbd_chain.sv -----
// Row of deque cells packed from cell zero, head entry held in cell zero.
`default_nettype none

module rbd_chain
   import rbd_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cell_op_type           op,
   input  wire logic [DATA_WIDTH-1:0] push_data,
   output logic [DATA_WIDTH-1:0]      head_data
);

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic                  cell_valid [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data, right_data;
      logic                  left_valid, right_valid;

      if (i == 0) begin : g_first
         assign left_data  = push_data;
         assign left_valid = 1'b1;
      end else begin : g_inner_left
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign right_data  = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner_right
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      rbd_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .push_data   (push_data),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .right_data  (right_data),
         .right_valid (right_valid),
         .data        (cell_data[i]),
         .valid       (cell_valid[i])
      );
   end

   assign head_data = cell_data[0];

endmodule

`default_nettype wire

// ----- rtl/ring_buffer_deque.sv -----
// Ring buffer deque: top level with two mirrored cell chains and output skid.
// Each accepted request's response is written to the output register, or to the skid while that register is held.
// Throughput: one request per cycle while the skid is empty; every action touches only the chain ends.
// The chain kept front-first and its mirror kept back-first each expose one end in cell zero.
// Reset (synchronous) clears the entry count, all occupied flags and the output stages;
// the stored words are not cleared.
`default_nettype none

module ring_buffer_deque
   import rbd_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rbd_req_if.sink     req,
   rbd_rsp_if.source   rsp
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]      count_ff, count_in;
   rsp_type               out_ff, out_in, skid_ff, skid_in, result;
   logic                  out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic                  accept, pop;
   logic                  full, empty;
   action_type            act;
   cell_op_type           op_front, op_back;
   logic [DATA_WIDTH-1:0] push_data, front_data, back_data;
   logic [DATA_WIDTH+VALUE_W-1:0] push_ext, front_ext, back_ext;
   logic [CNT_W+TOTAL_W-1:0]      count_ext;

   assign req.ready = !skid_valid_ff;
   assign accept    = req.valid && req.ready;
   assign pop       = out_valid_ff && rsp.ready;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign act   = action_type'(req.action);

   assign push_ext   = {{DATA_WIDTH{1'b0}}, req.push_value};
   assign push_data  = push_ext[DATA_WIDTH-1:0];
   assign front_ext  = {{VALUE_W{1'b0}}, front_data};
   assign back_ext   = {{VALUE_W{1'b0}}, back_data};
   assign count_ext  = {{TOTAL_W{1'b0}}, count_in};

   always_comb begin
      op_front            = CELL_HOLD;
      op_back             = CELL_HOLD;
      count_in            = count_ff;
      result              = '0;
      if (accept) begin
         case (act)
            ACT_PUSH_BACK: begin
               if (full) begin
                  result.push_dropped = 1'b1;
               end else begin
                  op_front = CELL_APPEND;
                  op_back  = CELL_SHIFT_IN;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ACT_PUSH_FRONT: begin
               if (full) begin
                  result.push_dropped = 1'b1;
               end else begin
                  op_front = CELL_SHIFT_IN;
                  op_back  = CELL_APPEND;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ACT_POP_FRONT: begin
               if (!empty) begin
                  op_front          = CELL_SHIFT_OUT;
                  op_back           = CELL_TRIM;
                  count_in          = count_ff - CNT_W'(1);
                  result.read_value = front_ext[VALUE_W-1:0];
                  result.read_valid = 1'b1;
               end
            end
            ACT_POP_BACK: begin
               if (!empty) begin
                  op_front          = CELL_TRIM;
                  op_back           = CELL_SHIFT_OUT;
                  count_in          = count_ff - CNT_W'(1);
                  result.read_value = back_ext[VALUE_W-1:0];
                  result.read_valid = 1'b1;
               end
            end
            ACT_PEEK_FRONT: begin
               if (!empty) begin
                  result.read_value = front_ext[VALUE_W-1:0];
                  result.read_valid = 1'b1;
               end
            end
            ACT_PEEK_BACK: begin
               if (!empty) begin
                  result.read_value = back_ext[VALUE_W-1:0];
                  result.read_valid = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      result.entry_total = count_ext[TOTAL_W-1:0];
      result.is_empty    = (count_in == '0);
   end

   // two-entry output: response register plus skid
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (accept) begin
         if (!out_valid_ff || pop) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   rbd_chain #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front_chain (
      .clock     (clock),
      .reset     (reset),
      .op        (op_front),
      .push_data (push_data),
      .head_data (front_data)
   );

   rbd_chain #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back_chain (
      .clock     (clock),
      .reset     (reset),
      .op        (op_back),
      .push_data (push_data),
      .head_data (back_data)
   );

   assign rsp.valid        = out_valid_ff;
   assign rsp.read_value   = out_ff.read_value;
   assign rsp.read_valid   = out_ff.read_valid;
   assign rsp.entry_total  = out_ff.entry_total;
   assign rsp.is_empty     = out_ff.is_empty;
   assign rsp.push_dropped = out_ff.push_dropped;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a transaction while output register is empty");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count moved without a transaction");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (count_ff == '0) && !out_valid_ff && !skid_valid_ff)
      else $error("reset did not clear control state");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_ff.read_valid && out_ff.push_dropped))
      else $error("read and dropped push flagged together");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the ring buffer deque: directed table, then random fill, drain and mixed traffic.
`timescale 1ns / 100ps

module testbench
   import rbd_pkg::*;
();

   localparam int          SLOTS       = 256;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          RANDOM_ITEMS = 626;
   localparam logic [2:0]  ACT_NOP_6   = 3'd6;
   localparam logic [2:0]  ACT_NOP_7   = 3'd7;
   localparam int          IDLE_PCT    = 12;

   typedef struct {
      logic [2:0]  act;
      logic [31:0] val;
      bit          typed;
      rsp_type     want;
   } stim_row_type;

   logic clock;
   logic reset;

   rbd_req_if req_ch ();
   rbd_rsp_if rsp_ch ();

   ring_buffer_deque dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // deque mirror
   logic [31:0] slot_words [SLOTS];
   logic [7:0]  front_idx;
   logic [7:0]  back_idx;
   logic [8:0]  entry_cnt;

   rsp_type replies_due [$];
   int      error_count;
   int      cycle_count;
   bit      quiet_stretch;

   always #5 clock = ~clock;

   function automatic rsp_type apply_deque_action(input logic [2:0] act, input logic [31:0] val);
      rsp_type r;
      r = '0;
      case (act)
         ACT_PUSH_BACK: begin
            if (entry_cnt >= SLOTS) begin
               r.push_dropped = 1'b1;
            end else begin
               slot_words[back_idx] = val;
               back_idx  = back_idx + 8'd1;
               entry_cnt = entry_cnt + 9'd1;
            end
         end
         ACT_PUSH_FRONT: begin
            if (entry_cnt >= SLOTS) begin
               r.push_dropped = 1'b1;
            end else begin
               front_idx = front_idx - 8'd1;
               slot_words[front_idx] = val;
               entry_cnt = entry_cnt + 9'd1;
            end
         end
         ACT_POP_FRONT: begin
            if (entry_cnt != 0) begin
               r.read_value = slot_words[front_idx];
               r.read_valid = 1'b1;
               front_idx    = front_idx + 8'd1;
               entry_cnt    = entry_cnt - 9'd1;
            end
         end
         ACT_POP_BACK: begin
            if (entry_cnt != 0) begin
               back_idx     = back_idx - 8'd1;
               r.read_value = slot_words[back_idx];
               r.read_valid = 1'b1;
               entry_cnt    = entry_cnt - 9'd1;
            end
         end
         ACT_PEEK_FRONT: begin
            if (entry_cnt != 0) begin
               r.read_value = slot_words[front_idx];
               r.read_valid = 1'b1;
            end
         end
         ACT_PEEK_BACK: begin
            if (entry_cnt != 0) begin
               r.read_value = slot_words[back_idx - 8'd1];
               r.read_valid = 1'b1;
            end
         end
         default: ;
      endcase
      r.entry_total = entry_cnt;
      r.is_empty    = (entry_cnt == 0);
      return r;
   endfunction

   function automatic stim_row_type mk_row(input logic [2:0] act, input logic [31:0] val,
                                        input bit typed, input logic [31:0] rv, input bit vld,
                                        input logic [8:0] total, input bit empty, input bit drop);
      stim_row_type s;
      s.act   = act;
      s.val   = val;
      s.typed = typed;
      s.want  = '{read_value: rv, read_valid: vld, entry_total: total,
                  is_empty: empty, push_dropped: drop};
      return s;
   endfunction

   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(0, 11))
         0:       w = 32'h0000_0000;
         1:       w = 32'hFFFF_FFFF;
         2:       w = 32'h7FFF_FFFF;
         3:       w = 32'h8000_0000;
         default: w = $urandom;
      endcase
      return w;
   endfunction

   // push_pct sets the bias toward filling or draining
   function automatic logic [2:0] pick_action(input int push_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)
         return $urandom_range(0, 1) ? ACT_NOP_7 : ACT_NOP_6;
      if (r < 3 + push_pct)
         return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return ACT_POP_FRONT;
         4, 5, 6, 7: return ACT_POP_BACK;
         8:          return ACT_PEEK_FRONT;
         default:    return ACT_PEEK_BACK;
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("cycle %0d: %s mismatch, expected %0h got %0h", cycle_count, field, want, got);
      error_count++;
   endtask

   task automatic check_reply();
      rsp_type want;
      if (replies_due.size() == 0) begin
         report_mismatch("unexpected response", 32'd0, 32'd1);
      end else begin
         want = replies_due[0];
         replies_due.delete(0);
         if (rsp_ch.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, rsp_ch.read_value);
         if (rsp_ch.read_valid !== want.read_valid)
            report_mismatch("read_valid", 32'(want.read_valid), 32'(rsp_ch.read_valid));
         if (rsp_ch.entry_total !== want.entry_total)
            report_mismatch("entry_total", 32'(want.entry_total), 32'(rsp_ch.entry_total));
         if (rsp_ch.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(want.is_empty), 32'(rsp_ch.is_empty));
         if (rsp_ch.push_dropped !== want.push_dropped)
            report_mismatch("push_dropped", 32'(want.push_dropped), 32'(rsp_ch.push_dropped));
      end
   endtask

   task automatic send_action(input logic [2:0] act, input logic [31:0] val, input bit typed,
                              input rsp_type want);
      rsp_type predicted;
      while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.push_value <= val;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_deque_action(act, val);
      replies_due.insert(replies_due.size(), typed ? want : predicted);
   endtask

   // response side: stall at random outside the quiet stretch, check every transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_reply();
         rsp_ch.ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      stim_row_type directed_rows [];
      rsp_type   none;
      int        sent;
      int        extra;

      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.action     = '0;
      req_ch.push_value = '0;
      quiet_stretch     = 1'b0;
      front_idx         = '0;
      back_idx          = '0;
      entry_cnt         = '0;
      none              = '0;

      directed_rows = '{
         mk_row(ACT_POP_FRONT,  32'h1234_5678, 1, 32'h0,         0, 9'd0, 1, 0),
         mk_row(ACT_POP_BACK,   32'hFFFF_FFFF, 1, 32'h0,         0, 9'd0, 1, 0),
         mk_row(ACT_PEEK_FRONT, 32'h0,         1, 32'h0,         0, 9'd0, 1, 0),
         mk_row(ACT_PEEK_BACK,  32'h0,         1, 32'h0,         0, 9'd0, 1, 0),
         mk_row(ACT_NOP_6,      32'hFFFF_FFFF, 1, 32'h0,         0, 9'd0, 1, 0),
         mk_row(ACT_NOP_7,      32'h8000_0000, 1, 32'h0,         0, 9'd0, 1, 0),
         mk_row(ACT_PUSH_BACK,  32'h7FFF_FFFF, 1, 32'h0,         0, 9'd1, 0, 0),
         mk_row(ACT_PUSH_FRONT, 32'h8000_0000, 1, 32'h0,         0, 9'd2, 0, 0),
         mk_row(ACT_PEEK_FRONT, 32'h0,         1, 32'h8000_0000, 1, 9'd2, 0, 0),
         mk_row(ACT_PEEK_BACK,  32'h0,         1, 32'h7FFF_FFFF, 1, 9'd2, 0, 0),
         mk_row(ACT_PUSH_BACK,  32'hFFFF_FFFF, 0, 32'h0, 0, 9'd0, 0, 0),
         mk_row(ACT_PUSH_FRONT, 32'h0000_0000, 0, 32'h0, 0, 9'd0, 0, 0),
         mk_row(ACT_PUSH_BACK,  32'h0000_0001, 0, 32'h0, 0, 9'd0, 0, 0),
         mk_row(ACT_NOP_6,      32'h5555_AAAA, 0, 32'h0, 0, 9'd0, 0, 0),
         mk_row(ACT_POP_BACK,   32'h0,         0, 32'h0, 0, 9'd0, 0, 0),
         mk_row(ACT_POP_FRONT,  32'h0,         0, 32'h0, 0, 9'd0, 0, 0),
         mk_row(ACT_PEEK_BACK,  32'h0,         0, 32'h0, 0, 9'd0, 0, 0),
         mk_row(ACT_POP_FRONT,  32'h0,         0, 32'h0, 0, 9'd0, 0, 0),
         mk_row(ACT_POP_BACK,   32'h0,         0, 32'h0, 0, 9'd0, 0, 0),
         mk_row(ACT_POP_FRONT,  32'h0,         0, 32'h0, 0, 9'd0, 0, 0),
         mk_row(ACT_POP_BACK,   32'hAAAA_5555, 1, 32'h0,         0, 9'd0, 1, 0),
         mk_row(ACT_PUSH_FRONT, 32'hA5A5_A5A5, 0, 32'h0, 0, 9'd0, 0, 0),
         mk_row(ACT_PEEK_FRONT, 32'h0,         0, 32'h0, 0, 9'd0, 0, 0),
         mk_row(ACT_POP_BACK,   32'h0,         0, 32'h0, 0, 9'd0, 0, 0)
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_action(directed_rows[i].act, directed_rows[i].val, directed_rows[i].typed,
                     directed_rows[i].want);

      // fill until full, then keep pushing into a full deque
      sent  = 0;
      extra = 0;
      while (extra < 8) begin
         quiet_stretch = (sent >= 100 && sent < 200);
         send_action(pick_action(95), pick_word(), 0, none);
         sent++;
         if (entry_cnt == SLOTS)
            extra++;
      end
      quiet_stretch = 1'b0;

      // drain until empty, then pop and peek an empty deque
      extra = 0;
      while (extra < 8) begin
         send_action(pick_action(3), pick_word(), 0, none);
         sent++;
         if (entry_cnt == 0)
            extra++;
      end

      while (sent < RANDOM_ITEMS) begin
         send_action(pick_action(45), pick_word(), 0, none);
         sent++;
      end
      req_ch.valid <= 1'b0;

      while (replies_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0 && replies_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/rbd_pkg.sv
rtl/rbd_req_if.sv
rtl/rbd_rsp_if.sv
rtl/rbd_cell.sv
rtl/rbd_chain.sv
rtl/ring_buffer_deque.sv
tb/testbench.sv
